/* rtl/core/rtp_pkg.sv */
package rtp_pkg;

    localparam int CH_W     = 8;
    localparam int STATUS_W = 3;
    localparam int SEC_W    = 39;

    // multiply-add datapath widths
    localparam int MAC_A_W  = 25;
    localparam int MAC_B_W  = 18;
    localparam int MAC_W    = MAC_A_W + MAC_B_W;

    localparam logic [4:0] FIXED_LEN = 5'd19;

    localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FORMAT  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NONNUM  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOZONE  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADOFF  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_BADMARK = 3'd6;
    localparam logic [STATUS_W-1:0] ST_TRAIL   = 3'd7;

    // day of the March-based year on which each month starts
    function automatic logic [8:0] month_start(input logic [3:0] m);
        logic [8:0] r;
        case (m)
            4'd1:    r = 9'd306;
            4'd2:    r = 9'd337;
            4'd3:    r = 9'd0;
            4'd4:    r = 9'd31;
            4'd5:    r = 9'd61;
            4'd6:    r = 9'd92;
            4'd7:    r = 9'd122;
            4'd8:    r = 9'd153;
            4'd9:    r = 9'd184;
            4'd10:   r = 9'd214;
            4'd11:   r = 9'd245;
            4'd12:   r = 9'd275;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/rtp_ifs.sv */
interface rtp_char_if;
    logic                     valid;
    logic                     ready;
    logic [rtp_pkg::CH_W-1:0] ch;
    logic                     last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface rtp_result_if;
    logic                             valid;
    logic                             ready;
    logic [rtp_pkg::STATUS_W-1:0]     status;
    logic signed [rtp_pkg::SEC_W-1:0] epoch_secs;

    modport source (output valid, output status, output epoch_secs, input ready);
    modport sink   (input valid, input status, input epoch_secs, output ready);
endinterface

/* rtl/core/rtp_mac.sv */
module rtp_mac (
    input  logic signed [rtp_pkg::MAC_W-1:0]   addend,
    input  logic signed [rtp_pkg::MAC_A_W-1:0] op_a,
    input  logic signed [rtp_pkg::MAC_B_W-1:0] op_b,
    output logic signed [rtp_pkg::MAC_W-1:0]   sum
);

    logic signed [rtp_pkg::MAC_W-1:0] product;

    assign product = op_a * op_b;
    assign sum     = addend + product;

endmodule

/* rtl/core/rfc3339_timestamp_parser_core.sv */
// Parses an RFC 3339 timestamp arriving one character per transaction, the last
// character flagged, and returns one result per string: a status code and the
// Unix seconds (zero unless the status is ok). Characters are taken one per
// cycle while a string streams in. After the last character the block is busy:
// it runs a check state and, when the text is valid, nine steps of the shared
// 25x18 multiply-add unit that build days-from-civil, the time of day and the
// zone offset, then loads the result register, straight after the check on an
// error; a result still waiting downstream holds the load until it is taken.
module rfc3339_timestamp_parser_core (
    input logic          clk,
    input logic          rst_n,
    rtp_char_if.sink     chars,
    rtp_result_if.source result
);

    typedef enum logic [3:0] {
        S_PARSE, S_CHECK, S_ERA, S_YOE, S_DOE, S_DAYS,
        S_SEC, S_HOUR, S_MIN, S_OFFH, S_OFFM, S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        SUF_START, SUF_FRAC, SUF_DONE, SUF_OFF0, SUF_OFF1, SUF_OFF2,
        SUF_OFF3, SUF_OFF4, SUF_OFFBAD, SUF_MARKBAD, SUF_TRAIL
    } suffix_t;

    state_t  state_reg, state_next;
    suffix_t suffix_reg, suffix_next;

    logic [4:0]  char_index_reg, char_index_next;
    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next;
    logic [6:0]  day_reg, day_next;
    logic [6:0]  hour_reg, hour_next;
    logic [6:0]  minute_reg, minute_next;
    logic [6:0]  second_reg, second_next;
    logic        off_neg_reg, off_neg_next;
    logic [6:0]  off_hours_reg, off_hours_next;
    logic [6:0]  off_minutes_reg, off_minutes_next;
    logic        fmt_err_reg, fmt_err_next;
    logic        num_err_reg, num_err_next;
    logic        short_reg, short_next;

    logic [4:0]                          era_reg, era_next;
    logic signed [rtp_pkg::MAC_W-1:0]    acc_reg, acc_next;
    logic [rtp_pkg::STATUS_W-1:0]        calc_status_reg, calc_status_next;

    logic                                out_valid_reg, out_valid_next;
    logic [rtp_pkg::STATUS_W-1:0]        out_status_reg, out_status_next;
    logic signed [rtp_pkg::SEC_W-1:0]    out_secs_reg, out_secs_next;

    logic                                accept;
    logic                                out_free;
    logic [rtp_pkg::CH_W-1:0]            c;
    logic                                is_digit;
    logic [3:0]                          dv;
    logic [rtp_pkg::STATUS_W-1:0]        status_calc;

    logic [14:0]                         year_biased;
    logic [8:0]                          yoe;
    logic [1:0]                          cent;
    logic [8:0]                          doy;
    logic signed [rtp_pkg::MAC_W-1:0]    doe_addend;

    logic signed [rtp_pkg::MAC_W-1:0]    mac_addend;
    logic signed [rtp_pkg::MAC_A_W-1:0]  mac_a;
    logic signed [rtp_pkg::MAC_B_W-1:0]  mac_b;
    logic signed [rtp_pkg::MAC_W-1:0]    mac_sum;

    rtp_mac u_mac (
        .addend (mac_addend),
        .op_a   (mac_a),
        .op_b   (mac_b),
        .sum    (mac_sum)
    );

    function automatic logic [6:0] push_digit(input logic [6:0] v, input logic [3:0] d);
        logic [10:0] t;
        t = {4'd0, v} * 11'd10 + {7'd0, d};
        return t[6:0];
    endfunction

    assign chars.ready         = (state_reg == S_PARSE);
    assign accept              = chars.valid && chars.ready;
    assign out_free            = !out_valid_reg || result.ready;
    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.epoch_secs   = out_secs_reg;

    assign c        = chars.ch;
    assign is_digit = (c >= 8'h30) && (c <= 8'h39);
    assign dv       = c[3:0];

    // bias the year by one era so that floor division stays non-negative
    assign year_biased = {1'b0, year_reg} + 15'd400 - {14'd0, (month_reg <= 7'd2)};
    assign yoe         = acc_reg[8:0];
    assign cent        = (yoe >= 9'd300) ? 2'd3 : (yoe >= 9'd200) ? 2'd2 :
                         (yoe >= 9'd100) ? 2'd1 : 2'd0;
    assign doy         = rtp_pkg::month_start(month_reg[3:0]) + {2'd0, day_reg} - 9'd1;
    // removes the epoch offset and the one era of bias
    assign doe_addend  = $signed({34'd0, doy}) + $signed({36'd0, yoe[8:2]})
                       - $signed({41'd0, cent}) - 43'sd865565;

    always_comb
    begin
        if (short_reg || fmt_err_reg)
            status_calc = rtp_pkg::ST_FORMAT;
        else if (num_err_reg)
            status_calc = rtp_pkg::ST_NONNUM;
        else if (month_reg < 7'd1 || month_reg > 7'd12 || day_reg < 7'd1 ||
                 day_reg > 7'd31 || hour_reg > 7'd23 || minute_reg > 7'd59 ||
                 second_reg > 7'd60)
            status_calc = rtp_pkg::ST_RANGE;
        else
        begin
            case (suffix_reg) inside
                SUF_START, SUF_FRAC:
                    status_calc = rtp_pkg::ST_NOZONE;
                SUF_OFFBAD, SUF_OFF0, SUF_OFF1, SUF_OFF2, SUF_OFF3, SUF_OFF4:
                    status_calc = rtp_pkg::ST_BADOFF;
                SUF_MARKBAD:
                    status_calc = rtp_pkg::ST_BADMARK;
                SUF_TRAIL:
                    status_calc = rtp_pkg::ST_TRAIL;
                default:
                    status_calc = rtp_pkg::ST_OK;
            endcase
        end
    end

    always_comb
    begin
        mac_addend = '0;
        mac_a      = '0;
        mac_b      = '0;
        unique case (state_reg)
            S_ERA:
            begin
                mac_a = $signed({10'd0, year_biased});
                mac_b = 18'sd5243;
            end
            S_YOE:
            begin
                // era straight from the reciprocal product, loaded into era_reg here
                mac_addend = $signed({28'd0, year_biased});
                mac_a      = $signed({20'd0, acc_reg[25:21]});
                mac_b      = -18'sd400;
            end
            S_DOE:
            begin
                mac_addend = doe_addend;
                mac_a      = $signed({16'd0, yoe});
                mac_b      = 18'sd365;
            end
            S_DAYS:
            begin
                mac_addend = acc_reg;
                mac_a      = 25'sd146097;
                mac_b      = $signed({13'd0, era_reg});
            end
            S_SEC:
            begin
                mac_addend = $signed({36'd0, second_reg});
                mac_a      = acc_reg[rtp_pkg::MAC_A_W-1:0];
                mac_b      = 18'sd86400;
            end
            S_HOUR:
            begin
                mac_addend = acc_reg;
                mac_a      = $signed({18'd0, hour_reg});
                mac_b      = 18'sd3600;
            end
            S_MIN:
            begin
                mac_addend = acc_reg;
                mac_a      = $signed({18'd0, minute_reg});
                mac_b      = 18'sd60;
            end
            S_OFFH:
            begin
                mac_addend = acc_reg;
                mac_a      = $signed({18'd0, off_hours_reg});
                mac_b      = off_neg_reg ? 18'sd3600 : -18'sd3600;
            end
            S_OFFM:
            begin
                mac_addend = acc_reg;
                mac_a      = $signed({18'd0, off_minutes_reg});
                mac_b      = off_neg_reg ? 18'sd60 : -18'sd60;
            end
            default:
            begin
                mac_addend = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        suffix_next      = suffix_reg;
        char_index_next  = char_index_reg;
        year_next        = year_reg;
        month_next       = month_reg;
        day_next         = day_reg;
        hour_next        = hour_reg;
        minute_next      = minute_reg;
        second_next      = second_reg;
        off_neg_next     = off_neg_reg;
        off_hours_next   = off_hours_reg;
        off_minutes_next = off_minutes_reg;
        fmt_err_next     = fmt_err_reg;
        num_err_next     = num_err_reg;
        short_next       = short_reg;
        era_next         = era_reg;
        acc_next         = acc_reg;
        calc_status_next = calc_status_reg;
        out_valid_next   = out_valid_reg && !result.ready;
        out_status_next  = out_status_reg;
        out_secs_next    = out_secs_reg;

        unique case (state_reg)
            S_PARSE:
            begin
                if (accept)
                begin
                    if (char_index_reg < rtp_pkg::FIXED_LEN)
                    begin
                        char_index_next = char_index_reg + 5'd1;
                        unique case (char_index_reg) inside
                            5'd0, 5'd1, 5'd2, 5'd3:
                            begin
                                if (is_digit)
                                    year_next = 14'(year_reg * 14'd10 + {10'd0, dv});
                                else
                                    num_err_next = 1'b1;
                            end
                            5'd4, 5'd7:
                                if (c != 8'h2D) fmt_err_next = 1'b1;
                            5'd10:
                                if (c != 8'h54 && c != 8'h74 && c != 8'h20)
                                    fmt_err_next = 1'b1;
                            5'd13, 5'd16:
                                if (c != 8'h3A) fmt_err_next = 1'b1;
                            5'd5, 5'd6:
                                if (is_digit) month_next = push_digit(month_reg, dv);
                                else num_err_next = 1'b1;
                            5'd8, 5'd9:
                                if (is_digit) day_next = push_digit(day_reg, dv);
                                else num_err_next = 1'b1;
                            5'd11, 5'd12:
                                if (is_digit) hour_next = push_digit(hour_reg, dv);
                                else num_err_next = 1'b1;
                            5'd14, 5'd15:
                                if (is_digit) minute_next = push_digit(minute_reg, dv);
                                else num_err_next = 1'b1;
                            default:
                                if (is_digit) second_next = push_digit(second_reg, dv);
                                else num_err_next = 1'b1;
                        endcase
                    end
                    else
                    begin
                        case (suffix_reg) inside
                            SUF_START, SUF_FRAC:
                            begin
                                if (suffix_reg == SUF_START && c == 8'h2E)
                                    suffix_next = SUF_FRAC;
                                else if (suffix_reg == SUF_FRAC && is_digit)
                                    suffix_next = SUF_FRAC;
                                else if (c == 8'h5A || c == 8'h7A)
                                    suffix_next = SUF_DONE;
                                else if (c == 8'h2B || c == 8'h2D)
                                begin
                                    suffix_next      = SUF_OFF0;
                                    off_neg_next     = (c == 8'h2D);
                                    off_hours_next   = '0;
                                    off_minutes_next = '0;
                                end
                                else
                                    suffix_next = SUF_MARKBAD;
                            end
                            SUF_DONE:
                                suffix_next = SUF_TRAIL;
                            SUF_OFF0, SUF_OFF1:
                            begin
                                if (is_digit)
                                begin
                                    off_hours_next = push_digit(off_hours_reg, dv);
                                    suffix_next = (suffix_reg == SUF_OFF0) ? SUF_OFF1 : SUF_OFF2;
                                end
                                else
                                    suffix_next = SUF_OFFBAD;
                            end
                            SUF_OFF2:
                                suffix_next = (c == 8'h3A) ? SUF_OFF3 : SUF_OFFBAD;
                            SUF_OFF3, SUF_OFF4:
                            begin
                                if (is_digit)
                                begin
                                    off_minutes_next = push_digit(off_minutes_reg, dv);
                                    suffix_next = (suffix_reg == SUF_OFF3) ? SUF_OFF4 : SUF_DONE;
                                end
                                else
                                    suffix_next = SUF_OFFBAD;
                            end
                            default:
                                suffix_next = suffix_reg;
                        endcase
                    end
                    if (chars.last)
                    begin
                        short_next = (char_index_reg < rtp_pkg::FIXED_LEN);
                        state_next = S_CHECK;
                    end
                end
            end
            S_CHECK:
            begin
                calc_status_next = status_calc;
                acc_next         = '0;
                state_next       = (status_calc == rtp_pkg::ST_OK) ? S_ERA : S_EMIT;
            end
            S_ERA:
            begin
                acc_next   = mac_sum;
                state_next = S_YOE;
            end
            S_YOE:
            begin
                // floor(year / 400) from the reciprocal product, one era high
                era_next   = acc_reg[25:21];
                acc_next   = mac_sum;
                state_next = S_DOE;
            end
            S_DOE:
            begin
                acc_next   = mac_sum;
                state_next = S_DAYS;
            end
            S_DAYS:
            begin
                acc_next   = mac_sum;
                state_next = S_SEC;
            end
            S_SEC:
            begin
                acc_next   = mac_sum;
                state_next = S_HOUR;
            end
            S_HOUR:
            begin
                acc_next   = mac_sum;
                state_next = S_MIN;
            end
            S_MIN:
            begin
                acc_next   = mac_sum;
                state_next = S_OFFH;
            end
            S_OFFH:
            begin
                acc_next   = mac_sum;
                state_next = S_OFFM;
            end
            S_OFFM:
            begin
                acc_next   = mac_sum;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_status_next  = calc_status_reg;
                    out_secs_next    = (calc_status_reg == rtp_pkg::ST_OK) ?
                                       acc_reg[rtp_pkg::SEC_W-1:0] : '0;
                    state_next       = S_PARSE;
                    suffix_next      = SUF_START;
                    char_index_next  = '0;
                    year_next        = '0;
                    month_next       = '0;
                    day_next         = '0;
                    hour_next        = '0;
                    minute_next      = '0;
                    second_next      = '0;
                    off_neg_next     = 1'b0;
                    off_hours_next   = '0;
                    off_minutes_next = '0;
                    fmt_err_next     = 1'b0;
                    num_err_next     = 1'b0;
                    short_next       = 1'b0;
                end
            end
            default:
            begin
                state_next = S_PARSE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_PARSE;
            suffix_reg      <= SUF_START;
            char_index_reg  <= '0;
            year_reg        <= '0;
            month_reg       <= '0;
            day_reg         <= '0;
            hour_reg        <= '0;
            minute_reg      <= '0;
            second_reg      <= '0;
            off_neg_reg     <= 1'b0;
            off_hours_reg   <= '0;
            off_minutes_reg <= '0;
            fmt_err_reg     <= 1'b0;
            num_err_reg     <= 1'b0;
            short_reg       <= 1'b0;
            era_reg         <= '0;
            acc_reg         <= '0;
            calc_status_reg <= rtp_pkg::ST_OK;
            out_valid_reg   <= 1'b0;
            out_status_reg  <= rtp_pkg::ST_OK;
            out_secs_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            suffix_reg      <= suffix_next;
            char_index_reg  <= char_index_next;
            year_reg        <= year_next;
            month_reg       <= month_next;
            day_reg         <= day_next;
            hour_reg        <= hour_next;
            minute_reg      <= minute_next;
            second_reg      <= second_next;
            off_neg_reg     <= off_neg_next;
            off_hours_reg   <= off_hours_next;
            off_minutes_reg <= off_minutes_next;
            fmt_err_reg     <= fmt_err_next;
            num_err_reg     <= num_err_next;
            short_reg       <= short_next;
            era_reg         <= era_next;
            acc_reg         <= acc_next;
            calc_status_reg <= calc_status_next;
            out_valid_reg   <= out_valid_next;
            out_status_reg  <= out_status_next;
            out_secs_reg    <= out_secs_next;
        end
    end

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && chars.last) |=> !chars.ready)
        else $error("character taken while a string is being finished");

    a_error_zero_secs: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status != rtp_pkg::ST_OK) |-> (result.epoch_secs == '0))
        else $error("seconds not zero on an error status");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        char_index_reg <= rtp_pkg::FIXED_LEN)
        else $error("character index beyond the fixed part");

    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && out_free) |=>
            (result.valid && state_reg == S_PARSE && char_index_reg == '0))
        else $error("result load did not restart the parser");

endmodule
